// ===== rtl/core/i2p_pkg.sv =====
// Shared definitions for the infix to postfix converter: token kind codes,
// operator codes and the operator precedence function.
// No dependencies.
package i2p_pkg;

  typedef logic [2:0] kind_t;
  typedef logic [3:0] out_kind_t;
  typedef logic [2:0] op_t;
  typedef logic [2:0] prec_t;

  localparam kind_t KIND_NUMBER    = 3'd0;
  localparam kind_t KIND_VARIABLE  = 3'd1;
  localparam kind_t KIND_FUNCTION  = 3'd2;
  localparam kind_t KIND_OPERATOR  = 3'd3;
  localparam kind_t KIND_LPAREN    = 3'd4;
  localparam kind_t KIND_RPAREN    = 3'd5;
  localparam kind_t KIND_COMMA     = 3'd6;
  localparam kind_t KIND_FACTORIAL = 3'd7;

  localparam out_kind_t KIND_END = 4'd8;

  localparam op_t OP_PLUS   = 3'd0;
  localparam op_t OP_MINUS  = 3'd1;
  localparam op_t OP_TIMES  = 3'd2;
  localparam op_t OP_DIVIDE = 3'd3;
  localparam op_t OP_MODULO = 3'd4;
  localparam op_t OP_POWER  = 3'd5;

  // Power binds tightest; unknown codes get the lowest precedence.
  function automatic prec_t prec_of(input op_t op);
    prec_t p;
    case (op) inside
      OP_POWER:                      p = 3'd4;
      OP_TIMES, OP_DIVIDE, OP_MODULO: p = 3'd3;
      OP_PLUS, OP_MINUS:             p = 3'd2;
      default:                       p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/infix_to_postfix_converter_unit.sv =====
// Infix to postfix converter top level: operator stack control and output stage.
// Depends on i2p_pkg and i2p_ram (operator stack storage).
//
// Usage: one infix token is taken per input transaction (in_valid high, in_stall
// low). The block then emits zero or more postfix tokens on the out_ channel.
// Numbers, variables and factorials pass straight through; functions and left
// parentheses are stacked; operators pop stacked operators of equal or higher
// precedence first. A transaction with in_end_of_expression set flushes the
// stack, flags its final result with out_last, or sends one end marker.
// Flow: tokens are handled one at a time and in_stall is high from the accepting
// edge until the token is done. A number, variable or factorial steps through the
// dispatch, end and finish states; a push adds the push state, each stack entry
// examined (each popped entry and the one that stops the search) a look state, the
// function check below a matched left parenthesis when entries remain a function
// state, and each entry flushed by an end token a flush state. The next token is
// taken in the cycle after in_stall falls. Results pass through a one-entry hold
// stage (so the last one can be flagged) and an output register. A stalled
// receiver freezes the output register and pauses the converter at its next result.
// Reset empties the stack and clears the sticky overflow flag; stack RAM
// contents are not cleared since only entries below the count are ever read.
module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH  = 32,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  i2p_pkg::kind_t           in_token_kind,
  input  i2p_pkg::op_t             in_op_code,
  input  logic [PAYLOAD_BITS-1:0]  in_payload,
  input  logic                     in_end_of_expression,
  output logic                     out_valid,
  input  logic                     out_stall,
  output i2p_pkg::out_kind_t       out_kind,
  output i2p_pkg::op_t             out_op_code,
  output logic [PAYLOAD_BITS-1:0]  out_payload,
  output logic                     out_last,
  output logic                     out_overflow_error
);

  import i2p_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int EW = 6 + PAYLOAD_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_DISP, S_LOOK, S_FUNC, S_PUSH, S_END, S_FLUSH, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  kind_t                   tok_kind_r, tok_kind_nxt;
  op_t                     tok_op_r, tok_op_nxt;
  logic [PAYLOAD_BITS-1:0] tok_pay_r, tok_pay_nxt;
  logic                    tok_end_r, tok_end_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic          overflow_r, overflow_nxt;

  logic                    hold_valid_r, hold_valid_nxt;
  out_kind_t               hold_kind_r, hold_kind_nxt;
  op_t                     hold_op_r, hold_op_nxt;
  logic [PAYLOAD_BITS-1:0] hold_pay_r, hold_pay_nxt;
  logic                    hold_ovf_r, hold_ovf_nxt;

  logic                    out_valid_r, out_valid_nxt;
  out_kind_t               out_kind_r, out_kind_nxt;
  op_t                     out_op_r, out_op_nxt;
  logic [PAYLOAD_BITS-1:0] out_pay_r, out_pay_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_ovf_r, out_ovf_nxt;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  logic [CW-1:0]           cnt_dec, cnt_dec2;
  kind_t                   top_kind;
  op_t                     top_op;
  logic [PAYLOAD_BITS-1:0] top_pay;
  logic                    can_move;
  logic                    emit;
  out_kind_t               emit_kind;
  op_t                     emit_op;
  logic [PAYLOAD_BITS-1:0] emit_pay;

  i2p_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign cnt_dec   = count_r - CW'(1);
  assign cnt_dec2  = count_r - CW'(2);
  assign top_kind  = mem_rdata[EW-1 -: 3];
  assign top_op    = mem_rdata[EW-4 -: 3];
  assign top_pay   = mem_rdata[PAYLOAD_BITS-1:0];
  assign can_move  = !out_valid_r || !out_stall;
  assign mem_waddr = count_r[AW-1:0];
  assign mem_wdata = {tok_kind_r, tok_op_r, tok_pay_r};

  always_comb begin
    state_nxt      = state_r;
    tok_kind_nxt   = tok_kind_r;
    tok_op_nxt     = tok_op_r;
    tok_pay_nxt    = tok_pay_r;
    tok_end_nxt    = tok_end_r;
    count_nxt      = count_r;
    overflow_nxt   = overflow_r;
    hold_valid_nxt = hold_valid_r;
    hold_kind_nxt  = hold_kind_r;
    hold_op_nxt    = hold_op_r;
    hold_pay_nxt   = hold_pay_r;
    hold_ovf_nxt   = hold_ovf_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_op_nxt     = out_op_r;
    out_pay_nxt    = out_pay_r;
    out_last_nxt   = out_last_r;
    out_ovf_nxt    = out_ovf_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_raddr      = cnt_dec[AW-1:0];
    emit           = 1'b0;
    emit_kind      = {1'b0, top_kind};
    emit_op        = top_op;
    emit_pay       = top_pay;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          tok_kind_nxt = in_token_kind;
          tok_op_nxt   = in_op_code;
          tok_pay_nxt  = in_payload;
          tok_end_nxt  = in_end_of_expression;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        case (tok_kind_r) inside
          KIND_NUMBER, KIND_VARIABLE, KIND_FACTORIAL: begin
            if (can_move) begin
              emit      = 1'b1;
              emit_kind = {1'b0, tok_kind_r};
              emit_op   = tok_op_r;
              emit_pay  = tok_pay_r;
              state_nxt = S_END;
            end
          end
          KIND_FUNCTION, KIND_LPAREN: begin
            state_nxt = S_PUSH;
          end
          KIND_OPERATOR: begin
            if (count_r != '0) begin
              mem_re    = 1'b1;
              state_nxt = S_LOOK;
            end else begin
              state_nxt = S_PUSH;
            end
          end
          default: begin
            if (count_r != '0) begin
              mem_re    = 1'b1;
              state_nxt = S_LOOK;
            end else begin
              state_nxt = S_END;
            end
          end
        endcase
      end
      S_LOOK: begin
        if ((tok_kind_r == KIND_OPERATOR &&
             !(top_kind == KIND_OPERATOR && prec_of(top_op) >= prec_of(tok_op_r))) ||
            (tok_kind_r == KIND_COMMA && top_kind == KIND_LPAREN)) begin
          // Stop popping: an operator now gets pushed, a comma is done.
          state_nxt = (tok_kind_r == KIND_OPERATOR) ? S_PUSH : S_END;
        end else if (tok_kind_r == KIND_RPAREN && top_kind == KIND_LPAREN) begin
          // Drop the matching left parenthesis and look for a function below it.
          count_nxt = cnt_dec;
          if (cnt_dec != '0) begin
            mem_re    = 1'b1;
            mem_raddr = cnt_dec2[AW-1:0];
            state_nxt = S_FUNC;
          end else begin
            state_nxt = S_END;
          end
        end else if (can_move) begin
          emit      = 1'b1;
          count_nxt = cnt_dec;
          if (cnt_dec != '0) begin
            mem_re    = 1'b1;
            mem_raddr = cnt_dec2[AW-1:0];
          end else begin
            state_nxt = (tok_kind_r == KIND_OPERATOR) ? S_PUSH : S_END;
          end
        end
      end
      S_FUNC: begin
        if (top_kind != KIND_FUNCTION) begin
          state_nxt = S_END;
        end else if (can_move) begin
          emit      = 1'b1;
          count_nxt = cnt_dec;
          state_nxt = S_END;
        end
      end
      S_PUSH: begin
        if (count_r == CW'(STACK_DEPTH)) begin
          overflow_nxt = 1'b1;
        end else begin
          mem_we    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
        state_nxt = S_END;
      end
      S_END: begin
        if (tok_end_r && count_r != '0) begin
          mem_re    = 1'b1;
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FLUSH: begin
        if (can_move) begin
          emit      = 1'b1;
          count_nxt = cnt_dec;
          if (cnt_dec != '0) begin
            mem_re    = 1'b1;
            mem_raddr = cnt_dec2[AW-1:0];
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (hold_valid_r) begin
          if (can_move) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = hold_kind_r;
            out_op_nxt     = hold_op_r;
            out_pay_nxt    = hold_pay_r;
            out_ovf_nxt    = hold_ovf_r;
            out_last_nxt   = tok_end_r;
            hold_valid_nxt = 1'b0;
            state_nxt      = S_IDLE;
          end
        end else if (tok_end_r) begin
          if (can_move) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_END;
            out_op_nxt    = OP_PLUS;
            out_pay_nxt   = '0;
            out_ovf_nxt   = overflow_r;
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // The newest result waits in the hold stage so that the final one of an
    // expression can still be flagged; the previous one moves on.
    if (emit) begin
      if (hold_valid_r) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = hold_kind_r;
        out_op_nxt    = hold_op_r;
        out_pay_nxt   = hold_pay_r;
        out_ovf_nxt   = hold_ovf_r;
        out_last_nxt  = 1'b0;
      end
      hold_valid_nxt = 1'b1;
      hold_kind_nxt  = emit_kind;
      hold_op_nxt    = emit_op;
      hold_pay_nxt   = emit_pay;
      hold_ovf_nxt   = overflow_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      overflow_r   <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      overflow_r   <= overflow_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      tok_kind_r   <= tok_kind_nxt;
      tok_op_r     <= tok_op_nxt;
      tok_pay_r    <= tok_pay_nxt;
      tok_end_r    <= tok_end_nxt;
      hold_kind_r  <= hold_kind_nxt;
      hold_op_r    <= hold_op_nxt;
      hold_pay_r   <= hold_pay_nxt;
      hold_ovf_r   <= hold_ovf_nxt;
      out_kind_r   <= out_kind_nxt;
      out_op_r     <= out_op_nxt;
      out_pay_r    <= out_pay_nxt;
      out_last_r   <= out_last_nxt;
      out_ovf_r    <= out_ovf_nxt;
    end
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_op_code        = out_op_r;
  assign out_payload        = out_pay_r;
  assign out_last           = out_last_r;
  assign out_overflow_error = out_ovf_r;

  // The stack count never runs past the RAM depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count exceeds depth");

  // A push is only written when there is room for it.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> count_r < CW'(STACK_DEPTH))
    else $error("stack write while full");

  // Once set, the overflow flag stays set until reset.
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |=> overflow_r)
    else $error("overflow flag cleared without reset");

  // Every result of a transaction has drained from the hold stage before the
  // next transaction can be taken.
  a_hold_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !hold_valid_r)
    else $error("hold stage occupied while idle");

endmodule

// ===== rtl/core/i2p_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Read data holds until the next read enable. No dependencies.
module i2p_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sim/infix_to_postfix_converter_unit_tb.sv =====
// Self-checking testbench for infix_to_postfix_converter_unit: directed and random
// token streams, a shunting-yard scoreboard, random input gaps and random output stalls.
// Depends on i2p_pkg and the converter RTL.
module infix_to_postfix_converter_unit_tb;
  import i2p_pkg::*;

  localparam int STACK_DEPTH  = 32;
  localparam int PAYLOAD_BITS = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int STOP_ITEMS   = 120;

  // Codes with no defined operator; the block gives them the lowest precedence.
  localparam op_t OP_UNDEF_LO = 3'd6;
  localparam op_t OP_UNDEF_HI = 3'd7;

  typedef struct packed {
    kind_t                   kind;
    op_t                     op;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    eoe;
  } token_t;

  typedef struct packed {
    out_kind_t               kind;
    op_t                     op;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    last;
    logic                    overflow;
  } postfix_t;

  class postfix_scoreboard;
    token_t   pending_ops[STACK_DEPTH];
    int       stack_used = 0;
    bit       overflow_seen = 1'b0;
    postfix_t released[$];
    postfix_t awaited[$];
    int       errors = 0;

    function int strength_of(op_t op);
      case (op)
        OP_POWER:                       return 4;
        OP_TIMES, OP_DIVIDE, OP_MODULO: return 3;
        OP_PLUS, OP_MINUS:              return 2;
        default:                        return 0;
      endcase
    endfunction

    function void release_token(token_t t);
      postfix_t r;
      r = '0;
      r.kind = out_kind_t'(t.kind);
      r.op = t.op;
      r.payload = t.payload;
      released.push_back(r);
    endfunction

    function void push_op(token_t t);
      if (stack_used >= STACK_DEPTH) begin
        overflow_seen = 1'b1;
      end else begin
        pending_ops[stack_used] = t;
        stack_used++;
      end
    endfunction

    function void pop_op();
      stack_used--;
      release_token(pending_ops[stack_used]);
    endfunction

    function void pop_to_open_paren();
      while (stack_used > 0 && pending_ops[stack_used-1].kind != KIND_LPAREN)
        pop_op();
    endfunction

    // Works out every postfix token released by one accepted input transaction.
    function void note_token(token_t t);
      postfix_t marker;
      released.delete();
      case (t.kind)
        KIND_NUMBER, KIND_VARIABLE, KIND_FACTORIAL: release_token(t);
        KIND_FUNCTION, KIND_LPAREN: push_op(t);
        KIND_OPERATOR: begin
          while (stack_used > 0 && pending_ops[stack_used-1].kind == KIND_OPERATOR &&
                 strength_of(pending_ops[stack_used-1].op) >= strength_of(t.op))
            pop_op();
          push_op(t);
        end
        KIND_RPAREN: begin
          pop_to_open_paren();
          // The matching left paren is dropped, then a function call closes.
          if (stack_used > 0) begin
            stack_used--;
            if (stack_used > 0 && pending_ops[stack_used-1].kind == KIND_FUNCTION)
              pop_op();
          end
        end
        default: pop_to_open_paren();
      endcase
      if (t.eoe) begin
        while (stack_used > 0)
          pop_op();
        if (released.size() == 0) begin
          marker = '0;
          marker.kind = KIND_END;
          released.push_back(marker);
        end
        released[released.size()-1].last = 1'b1;
      end
      foreach (released[i]) begin
        released[i].overflow = overflow_seen;
        awaited.push_back(released[i]);
      end
    endfunction

    function void check_result(postfix_t got);
      postfix_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: out_kind %0d, out_payload %h", got.kind, got.payload);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind) begin
        $error("out_kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.op !== want.op) begin
        $error("out_op_code: expected %0d, got %0d", want.op, got.op);
        errors++;
      end
      if (got.payload !== want.payload) begin
        $error("out_payload: expected %h, got %h", want.payload, got.payload);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("out_last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $error("out_overflow_error: expected %0b, got %0b", want.overflow, got.overflow);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  kind_t                   in_token_kind = KIND_NUMBER;
  op_t                     in_op_code = OP_PLUS;
  logic [PAYLOAD_BITS-1:0] in_payload = '0;
  logic                    in_end_of_expression = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  out_kind_t               out_kind;
  op_t                     out_op_code;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic                    out_last;
  logic                    out_overflow_error;

  postfix_scoreboard sb;
  token_t            expr_tokens[$];
  int                items_sent = 0;
  int                burst_left = 0;
  int                stall_left = 0;
  int                stall_mode = 0;
  int                cycle_count;

  infix_to_postfix_converter_unit #(
    .STACK_DEPTH (STACK_DEPTH),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_token_kind       (in_token_kind),
    .in_op_code          (in_op_code),
    .in_payload          (in_payload),
    .in_end_of_expression(in_end_of_expression),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_op_code         (out_op_code),
    .out_payload         (out_payload),
    .out_last            (out_last),
    .out_overflow_error  (out_overflow_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Inputs are noted before results are checked, so the order within an edge is fixed.
  always @(posedge clk) begin : monitor
    token_t   seen_in;
    postfix_t seen_out;
    if (rst_n) begin
      if (in_valid && in_stall === 1'b0) begin
        seen_in = {in_token_kind, in_op_code, in_payload, in_end_of_expression};
        sb.note_token(seen_in);
      end
      if (out_valid === 1'b1 && !out_stall) begin
        seen_out = {out_kind, out_op_code, out_payload, out_last, out_overflow_error};
        sb.check_result(seen_out);
      end
    end
  end

  // The receiver switches between free flow, random, heavy and periodic stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      2: out_stall <= ($urandom_range(0, 7) != 0);
      default: out_stall <= (stall_left % 5 < 2);
    endcase
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("no completion after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
           sb.pending());
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [PAYLOAD_BITS-1:0] rand_payload();
    return PAYLOAD_BITS'($urandom);
  endfunction

  function automatic op_t rand_op();
    if ($urandom_range(0, 9) == 0)
      return op_t'($urandom_range(6, 7));
    return op_t'($urandom_range(0, 5));
  endfunction

  function automatic void add_token(kind_t k, op_t o, logic [PAYLOAD_BITS-1:0] p, logic e);
    token_t t;
    t.kind = k;
    t.op = o;
    t.payload = p;
    t.eoe = e;
    expr_tokens.push_back(t);
  endfunction

  // Builds a well-formed expression of random shape, closed by an end token.
  function automatic void build_expression(int max_len);
    bit call_stack[$];
    bit want_operand;
    int choice;
    expr_tokens.delete();
    want_operand = 1'b1;
    forever begin
      choice = $urandom_range(0, 9);
      if (want_operand) begin
        if (choice < 6 || call_stack.size() >= 4 || expr_tokens.size() >= max_len) begin
          add_token(($urandom_range(0, 1) == 1) ? KIND_VARIABLE : KIND_NUMBER, rand_op(),
                    rand_payload(), 1'b0);
          if ($urandom_range(0, 4) == 0)
            add_token(KIND_FACTORIAL, rand_op(), rand_payload(), 1'b0);
          want_operand = 1'b0;
        end else if (choice < 8) begin
          add_token(KIND_LPAREN, rand_op(), rand_payload(), 1'b0);
          call_stack.push_back(1'b0);
        end else begin
          add_token(KIND_FUNCTION, rand_op(), rand_payload(), 1'b0);
          add_token(KIND_LPAREN, rand_op(), rand_payload(), 1'b0);
          call_stack.push_back(1'b1);
        end
      end else if (expr_tokens.size() >= max_len) begin
        if (call_stack.size() == 0)
          break;
        add_token(KIND_RPAREN, rand_op(), rand_payload(), 1'b0);
        void'(call_stack.pop_back());
      end else if (choice < 6) begin
        add_token(KIND_OPERATOR, rand_op(), rand_payload(), 1'b0);
        want_operand = 1'b1;
      end else if (choice < 8 && call_stack.size() > 0) begin
        add_token(KIND_RPAREN, rand_op(), rand_payload(), 1'b0);
        void'(call_stack.pop_back());
      end else if (choice == 8 && call_stack.size() > 0 && call_stack[call_stack.size()-1]) begin
        add_token(KIND_COMMA, rand_op(), rand_payload(), 1'b0);
        want_operand = 1'b1;
      end else if (choice == 9 && call_stack.size() == 0) begin
        break;
      end
    end
    expr_tokens[expr_tokens.size()-1].eoe = 1'b1;
  endfunction

  // Returns at the edge that accepted the transaction, with in_valid still high.
  task automatic send_token(token_t t);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_token_kind <= t.kind;
    in_op_code <= t.op;
    in_payload <= t.payload;
    in_end_of_expression <= t.eoe;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  task automatic send_all();
    foreach (expr_tokens[i])
      send_token(expr_tokens[i]);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int idx;
    int cut;
    bit nest_done;
    sb = new;
    nest_done = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // A lone number, then a comma on an empty stack, which leaves only the end marker.
    expr_tokens.delete();
    add_token(KIND_NUMBER, OP_PLUS, '0, 1'b1);
    add_token(KIND_COMMA, OP_UNDEF_HI, '1, 1'b1);
    // a - b * c ^ d ^ e / f % g! checks precedence and left-associative power.
    add_token(KIND_VARIABLE, OP_POWER, '1, 1'b0);
    add_token(KIND_OPERATOR, OP_MINUS, rand_payload(), 1'b0);
    add_token(KIND_NUMBER, OP_PLUS, rand_payload(), 1'b0);
    add_token(KIND_OPERATOR, OP_TIMES, rand_payload(), 1'b0);
    add_token(KIND_NUMBER, OP_MINUS, rand_payload(), 1'b0);
    add_token(KIND_OPERATOR, OP_POWER, rand_payload(), 1'b0);
    add_token(KIND_VARIABLE, OP_TIMES, rand_payload(), 1'b0);
    add_token(KIND_OPERATOR, OP_POWER, rand_payload(), 1'b0);
    add_token(KIND_NUMBER, OP_DIVIDE, rand_payload(), 1'b0);
    add_token(KIND_OPERATOR, OP_DIVIDE, rand_payload(), 1'b0);
    add_token(KIND_NUMBER, OP_MODULO, rand_payload(), 1'b0);
    add_token(KIND_OPERATOR, OP_MODULO, rand_payload(), 1'b0);
    add_token(KIND_NUMBER, OP_UNDEF_LO, rand_payload(), 1'b0);
    add_token(KIND_FACTORIAL, OP_UNDEF_HI, '0, 1'b1);
    // f(x + 1, 2): comma and right paren inside a function call.
    add_token(KIND_FUNCTION, OP_TIMES, rand_payload(), 1'b0);
    add_token(KIND_LPAREN, OP_PLUS, rand_payload(), 1'b0);
    add_token(KIND_VARIABLE, OP_PLUS, rand_payload(), 1'b0);
    add_token(KIND_OPERATOR, OP_PLUS, rand_payload(), 1'b0);
    add_token(KIND_NUMBER, OP_PLUS, rand_payload(), 1'b0);
    add_token(KIND_COMMA, OP_PLUS, rand_payload(), 1'b0);
    add_token(KIND_NUMBER, OP_PLUS, rand_payload(), 1'b0);
    add_token(KIND_RPAREN, OP_PLUS, rand_payload(), 1'b1);
    // An unmatched right paren empties the stack; an unmatched left paren is flushed.
    add_token(KIND_OPERATOR, OP_UNDEF_LO, rand_payload(), 1'b0);
    add_token(KIND_RPAREN, OP_UNDEF_HI, rand_payload(), 1'b1);
    add_token(KIND_LPAREN, OP_POWER, '1, 1'b1);
    send_all();
    hold_until_drained();

    while (items_sent < STOP_ITEMS) begin
      if (!nest_done && items_sent >= 60) begin
        // One push more than the stack holds, then a flush of the full stack.
        expr_tokens.delete();
        for (idx = 0; idx <= STACK_DEPTH; idx++)
          add_token(($urandom_range(0, 1) == 1) ? KIND_LPAREN : KIND_FUNCTION, rand_op(),
                    rand_payload(), 1'b0);
        add_token(KIND_NUMBER, rand_op(), rand_payload(), 1'b1);
        send_all();
        nest_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        7, 8: begin
          build_expression($urandom_range(3, 14));
          case ($urandom_range(0, 2))
            0: begin
              idx = $urandom_range(0, expr_tokens.size() - 1);
              expr_tokens[idx].kind = kind_t'($urandom_range(0, 7));
            end
            1: begin
              cut = $urandom_range(1, expr_tokens.size());
              while (expr_tokens.size() > cut) void'(expr_tokens.pop_back());
              expr_tokens[expr_tokens.size()-1].eoe = 1'b1;
            end
            default: expr_tokens[expr_tokens.size()-1].eoe = 1'b0;
          endcase
        end
        9: begin
          expr_tokens.delete();
          repeat ($urandom_range(1, 6))
            add_token(kind_t'($urandom_range(0, 7)), op_t'($urandom_range(0, 7)),
                      rand_payload(), ($urandom_range(0, 3) == 0));
        end
        default: build_expression($urandom_range(3, 14));
      endcase
      send_all();
      if ($urandom_range(0, 7) == 0)
        hold_until_drained();
    end

    hold_until_drained();
    repeat (60) @(posedge clk);
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
